// ===== sv/jof_pkg.sv =====
package jof_pkg;

    localparam int STORE_BYTES = 64;
    localparam int STORE_CAP   = STORE_BYTES - 1;
    localparam int LEN_BITS    = $clog2(STORE_BYTES);
    localparam int ADDR_BITS   = (STORE_CAP > 1) ? $clog2(STORE_CAP) : 1;
    localparam int DEPTH_BITS  = 8;

    localparam logic [LEN_BITS-1:0]   LEN_CAP   = LEN_BITS'(STORE_CAP);
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic CMD_PAYLOAD    = 1'b0;
    localparam logic CMD_LINK_RESET = 1'b1;

    typedef enum logic [1:0] {
        ST_BYTE      = 2'd0,
        ST_DROPPED   = 2'd1,
        ST_MALFORMED = 2'd2
    } t_status;

endpackage

// ===== sv/jof_if.sv =====
interface jof_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] in_byte;

    modport source (output valid, output command, output in_byte, input ready);
    modport sink   (input valid, input command, input in_byte, output ready);
endinterface

interface jof_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;

    modport source (output valid, output out_byte, output status, output last, input ready);
    modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

// ===== sv/json_object_stream_framer_top.sv =====
// JSON object framer. Bytes arrive one item per cycle on i_in while the block is idle;
// bytes before an opening brace and all NUL bytes are skipped, and every byte of an
// object that fits is written into a store of STORE_BYTES-1 entries. When the bracket
// depth returns to zero the object is replayed from the store on o_out, each byte going
// through a store read (S_RD) and a load of the output register (S_LOAD), which waits
// while the sink stalls; i_in is held off for the whole replay. An overflowed object
// gives a dropped status instead, loaded from S_STATUS like a malformed one. A finished
// result waits in the output register while the next input item is taken.
module json_object_stream_framer_top
    import jof_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    jof_in_if.sink         i_in,
    jof_out_if.source      o_out
);

    typedef enum logic [1:0] {S_IDLE, S_RD, S_LOAD, S_STATUS} t_state;

    t_state                r_state, n_state;
    logic                  r_started, n_started;
    logic                  r_in_string, n_in_string;
    logic                  r_escape, n_escape;
    logic [DEPTH_BITS-1:0] r_depth, n_depth;
    logic [LEN_BITS-1:0]   r_len, n_len;
    logic                  r_ovf, n_ovf;
    logic [ADDR_BITS-1:0]  r_rd_addr, n_rd_addr;
    t_status               r_pend, n_pend;
    logic                  r_out_valid, n_out_valid;
    logic [7:0]            r_out_byte, n_out_byte;
    t_status               r_out_status, n_out_status;
    logic                  r_out_last, n_out_last;

    logic [7:0]            r_mem [STORE_CAP];
    logic [7:0]            r_rd_data;
    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr;

    logic                  in_fire;
    logic                  out_free;
    logic [7:0]            b;
    logic [DEPTH_BITS-1:0] dec_depth;

    assign in_fire  = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign b        = i_in.in_byte;

    always_comb begin
        n_state      = r_state;
        n_started    = r_started;
        n_in_string  = r_in_string;
        n_escape     = r_escape;
        n_depth      = r_depth;
        n_len        = r_len;
        n_ovf        = r_ovf;
        n_rd_addr    = r_rd_addr;
        n_pend       = r_pend;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_byte   = r_out_byte;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        wr_en        = 1'b0;
        wr_addr      = r_len[ADDR_BITS-1:0];
        dec_depth    = (r_depth != '0) ? r_depth - 1'b1 : '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in.command == CMD_LINK_RESET) begin
                        n_started   = 1'b0;
                        n_in_string = 1'b0;
                        n_escape    = 1'b0;
                        n_depth     = '0;
                        n_len       = '0;
                        n_ovf       = 1'b0;
                    end else if (b == CH_NUL) begin
                        // skip NUL everywhere
                    end else if (b == CH_LF || b == CH_CR) begin
                        if (r_started) begin
                            n_pend      = ST_MALFORMED;
                            n_state     = S_STATUS;
                            n_started   = 1'b0;
                            n_in_string = 1'b0;
                            n_escape    = 1'b0;
                            n_depth     = '0;
                            n_len       = '0;
                            n_ovf       = 1'b0;
                        end
                    end else if (!r_started) begin
                        if (b == CH_LBRACE) begin
                            n_started   = 1'b1;
                            n_in_string = 1'b0;
                            n_escape    = 1'b0;
                            n_depth     = DEPTH_BITS'(1);
                            n_len       = LEN_BITS'(1);
                            n_ovf       = 1'b0;
                            wr_en       = 1'b1;
                            wr_addr     = '0;
                        end
                    end else begin
                        if (r_len < LEN_CAP) begin
                            wr_en = 1'b1;
                            n_len = r_len + 1'b1;
                        end else begin
                            n_ovf = 1'b1;
                        end

                        if (r_in_string) begin
                            if (r_escape) begin
                                n_escape = 1'b0;
                            end else if (b == CH_BSLASH) begin
                                n_escape = 1'b1;
                            end else if (b == CH_QUOTE) begin
                                n_in_string = 1'b0;
                            end
                        end else if (b == CH_QUOTE) begin
                            n_in_string = 1'b1;
                        end else if (b == CH_LBRACE || b == CH_LBRACK) begin
                            if (r_depth != DEPTH_MAX) begin
                                n_depth = r_depth + 1'b1;
                            end
                        end else if (b == CH_RBRACE || b == CH_RBRACK) begin
                            n_depth = dec_depth;
                            if (dec_depth == '0) begin
                                n_started   = 1'b0;
                                n_in_string = 1'b0;
                                n_escape    = 1'b0;
                                if (n_ovf) begin
                                    n_ovf   = 1'b0;
                                    n_pend  = ST_DROPPED;
                                    n_state = S_STATUS;
                                    n_len   = '0;
                                end else begin
                                    // keep length for the replay
                                    n_rd_addr = '0;
                                    n_state   = S_RD;
                                end
                            end
                        end
                    end
                end
            end
            S_RD: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = r_rd_data;
                    n_out_status = ST_BYTE;
                    n_out_last   = (LEN_BITS'(r_rd_addr) + 1'b1 == r_len);
                    if (LEN_BITS'(r_rd_addr) + 1'b1 == r_len) begin
                        n_len   = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_rd_addr = r_rd_addr + 1'b1;
                        n_state   = S_RD;
                    end
                end
            end
            S_STATUS: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_byte   = CH_NUL;
                    n_out_status = r_pend;
                    n_out_last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_started   <= 1'b0;
            r_in_string <= 1'b0;
            r_escape    <= 1'b0;
            r_depth     <= '0;
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_started   <= n_started;
            r_in_string <= n_in_string;
            r_escape    <= n_escape;
            r_depth     <= n_depth;
            r_len       <= n_len;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
        r_rd_addr    <= n_rd_addr;
        r_pend       <= n_pend;
        r_out_byte   <= n_out_byte;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= b;
        end
        r_rd_data <= r_mem[r_rd_addr];
    end

    assign i_in.ready     = (r_state == S_IDLE);
    assign o_out.valid    = r_out_valid;
    assign o_out.out_byte = r_out_byte;
    assign o_out.status   = r_out_status;
    assign o_out.last     = r_out_last;

endmodule

// ===== sv/jof_checker.sv =====
module jof_checker
    import jof_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_command,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic [1:0] i_out_status,
    input logic       i_out_last
);

    // status results stand alone and carry no byte
    a_status_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status != ST_BYTE) |-> (i_out_last && i_out_byte == CH_NUL))
        else $error("status result without last or with nonzero byte");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result shown right after reset");

    // a link reset never produces a result
    a_link_reset_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_command == CMD_LINK_RESET && !i_out_valid)
            |=> !i_out_valid)
        else $error("result after link reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_byte) && $stable(i_out_status) && $stable(i_out_last)))
        else $error("stalled result changed");

endmodule

bind json_object_stream_framer_top jof_checker u_jof_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_command (i_in.command),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_byte   (o_out.out_byte),
    .i_out_status (o_out.status),
    .i_out_last   (o_out.last)
);
